// File: hw/rtl/ppm_pkg.sv
`timescale 1ns / 1ps

package ppm_pkg;

  localparam int CFG_W     = 17;
  localparam int SLOPE_W   = 16;
  localparam int OFFSET_W  = 17;
  localparam int VOLT_W    = 10;
  localparam int POWER_W   = 17;
  localparam int TOTAL_W   = 19;
  localparam int CFG_IDX_W = 2;
  localparam int PHASES    = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT   = 2'd2;

  localparam logic [SLOPE_W-1:0]  SLOPE_RESET  = 16'd14459;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 17'd0;
  localparam logic [VOLT_W-1:0]   VOLT_RESET   = 10'd240;

  localparam logic [POWER_W-1:0] POWER_MAX = 17'h0ffff;
  localparam logic [POWER_W-1:0] POWER_MIN = 17'h10000;

  // quotient magnitude is capped one past the negative limit before dividing by 5
  localparam int QUOT_W   = 19;
  localparam logic [QUOT_W-1:0] QUOT_CLAMP = 19'd327685;
  localparam int RECIP_W  = 20;
  localparam logic [RECIP_W-1:0] RECIP_5 = 20'd838861;
  localparam int RECIP_SHIFT = 22;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_VMUL,
    S_MAG,
    S_DIV,
    S_SAT,
    S_TOTAL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic close;
    logic mul;
    logic add;
    logic vmul;
    logic mag;
    logic div;
    logic sat;
    logic total;
  } ppm_cmd_t;

endpackage

// File: hw/rtl/ppm_ctrl.sv
`timescale 1ns / 1ps

module ppm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              window_end,
  input  logic              out_stall,
  output logic              in_stall,
  output logic              out_valid,
  output ppm_pkg::ppm_cmd_t cmd
);

  ppm_pkg::state_t state;
  ppm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      ppm_pkg::S_IDLE: begin
        in_stall = 1'b0;
      end
      ppm_pkg::S_MUL:   cmd.mul   = 1'b1;
      ppm_pkg::S_ADD:   cmd.add   = 1'b1;
      ppm_pkg::S_VMUL:  cmd.vmul  = 1'b1;
      ppm_pkg::S_MAG:   cmd.mag   = 1'b1;
      ppm_pkg::S_DIV:   cmd.div   = 1'b1;
      ppm_pkg::S_SAT:   cmd.sat   = 1'b1;
      ppm_pkg::S_TOTAL: cmd.total = 1'b1;
      ppm_pkg::S_OUT: begin
        out_valid = 1'b1;
        // a closing sample waits until the result register is free
        in_stall  = out_stall & window_end;
      end
      default: ;
    endcase
    if (rst) begin
      in_stall = 1'b1;
    end
    cmd.take  = in_valid & ~in_stall;
    cmd.close = cmd.take & window_end;

    unique case (state)
      ppm_pkg::S_IDLE:  if (cmd.close) state_next = ppm_pkg::S_MUL;
      ppm_pkg::S_MUL:   state_next = ppm_pkg::S_ADD;
      ppm_pkg::S_ADD:   state_next = ppm_pkg::S_VMUL;
      ppm_pkg::S_VMUL:  state_next = ppm_pkg::S_MAG;
      ppm_pkg::S_MAG:   state_next = ppm_pkg::S_DIV;
      ppm_pkg::S_DIV:   state_next = ppm_pkg::S_SAT;
      ppm_pkg::S_SAT:   state_next = ppm_pkg::S_TOTAL;
      ppm_pkg::S_TOTAL: state_next = ppm_pkg::S_OUT;
      ppm_pkg::S_OUT: begin
        if (!out_stall) begin
          state_next = cmd.close ? ppm_pkg::S_MUL : ppm_pkg::S_IDLE;
        end
      end
      default: state_next = ppm_pkg::S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/ppm_datapath.sv
`timescale 1ns / 1ps

module ppm_datapath #(
  parameter int SAMPLE_BITS = 12,
  parameter int CH_W        = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ppm_pkg::ppm_cmd_t                  cmd,
  input  logic [CH_W-1:0]                    channel,
  input  logic [SAMPLE_BITS-1:0]             sample,
  input  logic                               cfg_we,
  input  logic [ppm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppm_pkg::CFG_W-1:0]          cfg_data,
  output logic [CH_W-1:0]                    result_channel,
  output logic signed [ppm_pkg::POWER_W-1:0] power_watts,
  output logic signed [ppm_pkg::TOTAL_W-1:0] pump_total_watts,
  output logic                               saturated
);

  localparam int SB    = SAMPLE_BITS;
  localparam int AW    = SB + 26;
  localparam int NW    = AW + 11;
  localparam int SHIFT = SB + 13;
  localparam int XW    = NW - SHIFT;
  localparam int PRODW = ppm_pkg::QUOT_W + ppm_pkg::RECIP_W;
  localparam logic [SB:0] FULL_SCALE = {1'b1, {SB{1'b0}}};

  logic [ppm_pkg::SLOPE_W-1:0]         slope_q12;
  logic signed [ppm_pkg::OFFSET_W-1:0] offset_q12;
  logic [ppm_pkg::VOLT_W-1:0]          line_voltage;

  always_ff @(posedge clk) begin
    if (rst) begin
      slope_q12    <= ppm_pkg::SLOPE_RESET;
      offset_q12   <= ppm_pkg::OFFSET_RESET;
      line_voltage <= ppm_pkg::VOLT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppm_pkg::CFG_SLOPE:  slope_q12    <= cfg_data[ppm_pkg::SLOPE_W-1:0];
        ppm_pkg::CFG_OFFSET: offset_q12   <= cfg_data[ppm_pkg::OFFSET_W-1:0];
        ppm_pkg::CFG_VOLT:   line_voltage <= cfg_data[ppm_pkg::VOLT_W-1:0];
        default: ;
      endcase
    end
  end

  // min/max window shared by all channels
  logic [SB-1:0] win_high;
  logic [SB:0]   win_low;
  logic [SB-1:0] high_new;
  logic [SB:0]   low_new;
  logic [SB-1:0] span;
  logic [CH_W-1:0] ch_hold;

  assign high_new = (sample > win_high) ? sample : win_high;
  assign low_new  = ({1'b0, sample} < win_low) ? {1'b0, sample} : win_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_high <= '0;
      win_low  <= FULL_SCALE;
    end else if (cmd.close) begin
      win_high <= '0;
      win_low  <= FULL_SCALE;
    end else if (cmd.take) begin
      win_high <= high_new;
      win_low  <= low_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close) begin
      span    <= high_new - low_new[SB-1:0];
      ch_hold <= channel;
    end
  end

  // power = trunc(V * (span*33*slope + offset*40960) / (5 * 2^SHIFT))
  logic [SB+15:0]        prod1;
  logic signed [AW-1:0]  off_term;
  logic                  below_cut;
  logic [SB+5:0]         span33;
  logic signed [AW-1:0]  off_a;
  logic signed [AW-1:0]  off_b;
  logic [SB+21:0]        p33;
  logic signed [AW-1:0]  acc;
  logic signed [10:0]    volt_s;
  logic signed [NW-1:0]  num;
  logic [NW-1:0]         mag;
  logic [XW-1:0]         xs;
  logic [ppm_pkg::QUOT_W-1:0] xq;
  logic                  neg;
  logic [PRODW-1:0]      qprod;
  logic [ppm_pkg::POWER_W-1:0] quot;
  logic [ppm_pkg::POWER_W-1:0] power_calc;
  logic                  sat_calc;

  assign span33 = {span, 5'b0} + {6'b0, span};
  assign off_a  = {{(AW-32){offset_q12[16]}}, offset_q12, 15'b0};
  assign off_b  = {{(AW-30){offset_q12[16]}}, offset_q12, 13'b0};
  assign p33    = {1'b0, prod1, 5'b0} + {6'b0, prod1};
  assign volt_s = {1'b0, line_voltage};
  assign mag    = num[NW-1] ? (NW'(0) - num) : num;
  assign xs     = mag[NW-1:SHIFT];
  assign qprod  = PRODW'(xq) * PRODW'(ppm_pkg::RECIP_5);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod1     <= span * slope_q12;
      off_term  <= off_a + off_b;
      below_cut <= span33 < {5'b0, FULL_SCALE};
    end
    if (cmd.add) begin
      acc <= $signed({{(AW-SB-22){1'b0}}, p33}) + off_term;
    end
    if (cmd.vmul) begin
      num <= acc * volt_s;
    end
    if (cmd.mag) begin
      neg <= num[NW-1];
      xq  <= (xs > XW'(ppm_pkg::QUOT_CLAMP)) ? ppm_pkg::QUOT_CLAMP
                                             : xs[ppm_pkg::QUOT_W-1:0];
    end
    if (cmd.div) begin
      quot <= qprod[PRODW-1-(PRODW-ppm_pkg::RECIP_SHIFT-ppm_pkg::POWER_W):
                    ppm_pkg::RECIP_SHIFT];
    end
  end

  always_comb begin
    power_calc = quot;
    sat_calc   = 1'b0;
    if (below_cut) begin
      power_calc = '0;
    end else if (!neg) begin
      if (quot[ppm_pkg::POWER_W-1]) begin
        power_calc = ppm_pkg::POWER_MAX;
        sat_calc   = 1'b1;
      end
    end else if (quot > ppm_pkg::POWER_MIN) begin
      power_calc = ppm_pkg::POWER_MIN;
      sat_calc   = 1'b1;
    end else begin
      power_calc = ppm_pkg::POWER_W'(0) - quot;
    end
  end

  logic signed [ppm_pkg::POWER_W-1:0] phase_power [ppm_pkg::PHASES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ppm_pkg::PHASES; i++) begin
        phase_power[i] <= '0;
      end
    end else if (cmd.sat) begin
      for (int i = 0; i < ppm_pkg::PHASES; i++) begin
        if (32'(ch_hold) == i) begin
          phase_power[i] <= power_calc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sat) begin
      result_channel <= ch_hold;
      power_watts    <= power_calc;
      saturated      <= sat_calc;
    end
    if (cmd.total) begin
      pump_total_watts <= {{2{phase_power[0][16]}}, phase_power[0]}
                        + {{2{phase_power[1][16]}}, phase_power[1]}
                        + {{2{phase_power[2][16]}}, phase_power[2]};
    end
  end

  a_window_restart: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.close) |-> (win_high == '0) && (win_low == FULL_SCALE))
    else $error("window not restarted after close");

endmodule

// File: hw/rtl/peak_to_peak_phase_power_meter.sv
`timescale 1ns / 1ps

// Peak-to-peak power meter for current clamps. Samples are taken one per
// cycle while the input does not stall; one min/max tracker is shared by
// all channels. The sample marked window_end starts a fixed sequence of seven
// arithmetic steps (slope multiply, offset add, voltage multiply, magnitude
// and scale, divide by five through a reciprocal multiply, saturate and store,
// phase total); the input stalls while they run, and the result then shows on
// the output. While a result waits, samples that do not close a window keep
// flowing; a closing one waits for the result to be taken. Phases 0..2 keep
// their last power for the pump total.
module peak_to_peak_phase_power_meter #(
  parameter int SAMPLE_BITS = 12,
  parameter int CHANNELS    = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [$clog2(CHANNELS)-1:0]         channel,
  input  logic [SAMPLE_BITS-1:0]              sample,
  input  logic                                window_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [$clog2(CHANNELS)-1:0]         result_channel,
  output logic signed [ppm_pkg::POWER_W-1:0]  power_watts,
  output logic signed [ppm_pkg::TOTAL_W-1:0]  pump_total_watts,
  output logic                                saturated,
  input  logic                                cfg_we,
  input  logic [ppm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ppm_pkg::CFG_W-1:0]           cfg_data
);

  localparam int CH_W = $clog2(CHANNELS);

  ppm_pkg::ppm_cmd_t cmd;

  ppm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .window_end (window_end),
    .out_stall  (out_stall),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .cmd        (cmd)
  );

  ppm_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CH_W        (CH_W)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .channel          (channel),
    .sample           (sample),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .result_channel   (result_channel),
    .power_watts      (power_watts),
    .pump_total_watts (pump_total_watts),
    .saturated        (saturated)
  );

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (power_watts == ppm_pkg::POWER_MAX) || (power_watts == ppm_pkg::POWER_MIN))
    else $error("saturated flag without clipped power");

  a_close_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && in_valid && window_end |-> in_stall)
    else $error("closing request taken while result pending");

  a_close_starts_math: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && window_end |=> !out_valid)
    else $error("result shown right after window close");

endmodule

// File: tb/sv/tb_peak_to_peak_phase_power_meter.sv
`timescale 1ns / 1ps

module tb_peak_to_peak_phase_power_meter;

  localparam logic [ppm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int FULL_SCALE = 4096;
  localparam longint POWER_DIVISOR = longint'(10) * 4096 * 4096;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [1:0]                  chan;
    logic [ppm_pkg::POWER_W-1:0] watts;
    logic [ppm_pkg::TOTAL_W-1:0] total;
    logic                        clip;
  } reading_t;

  class power_ledger;
    int slope_q;
    int offset_q;
    int volts;
    int top;
    int bottom;
    int stored[ppm_pkg::PHASES];
    reading_t readings[$];
    int failures;

    function new();
      slope_q = ppm_pkg::SLOPE_RESET;
      offset_q = $signed(ppm_pkg::OFFSET_RESET);
      volts = ppm_pkg::VOLT_RESET;
      top = 0;
      bottom = FULL_SCALE;
      foreach (stored[i]) stored[i] = 0;
      failures = 0;
    endfunction

    function void set_register(logic [ppm_pkg::CFG_IDX_W-1:0] idx,
                               logic [ppm_pkg::CFG_W-1:0] d);
      case (idx)
        ppm_pkg::CFG_SLOPE:  slope_q = d[ppm_pkg::SLOPE_W-1:0];
        ppm_pkg::CFG_OFFSET: offset_q = $signed(d[ppm_pkg::OFFSET_W-1:0]);
        ppm_pkg::CFG_VOLT:   volts = d[ppm_pkg::VOLT_W-1:0];
        default: ;
      endcase
    endfunction

    // fold one sample into the shared window, predict a reading when it closes
    function void take_sample(logic [1:0] ch, logic [11:0] s, logic last);
      int span;
      longint num;
      longint quo;
      int sum;
      reading_t r;
      if (s > top) top = s;
      if (s < bottom) bottom = s;
      if (!last) return;
      span = top - bottom;
      quo = 0;
      r.clip = 1'b0;
      if (span * 33 >= FULL_SCALE) begin
        num = longint'(span) * 33 * longint'(slope_q) * longint'(volts)
            + longint'(offset_q) * longint'(volts) * 40960;
        quo = num / POWER_DIVISOR;
        if (quo > $signed(ppm_pkg::POWER_MAX)) begin
          quo = $signed(ppm_pkg::POWER_MAX);
          r.clip = 1'b1;
        end else if (quo < $signed(ppm_pkg::POWER_MIN)) begin
          quo = $signed(ppm_pkg::POWER_MIN);
          r.clip = 1'b1;
        end
      end
      if (ch < ppm_pkg::PHASES) stored[ch] = int'(quo);
      sum = stored[0] + stored[1] + stored[2];
      r.chan = ch;
      r.watts = quo[ppm_pkg::POWER_W-1:0];
      r.total = sum[ppm_pkg::TOTAL_W-1:0];
      readings.push_back(r);
      top = 0;
      bottom = FULL_SCALE;
    endfunction

    function void check_reading(logic [1:0] ch, logic [ppm_pkg::POWER_W-1:0] watts,
                                logic [ppm_pkg::TOTAL_W-1:0] total, logic clip);
      reading_t want;
      if (readings.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: ch %0d power %0d total %0d sat %0b",
                   ch, $signed(watts), $signed(total), clip);
        return;
      end
      want = readings.pop_front();
      if (want.chan !== ch || want.watts !== watts || want.total !== total ||
          want.clip !== clip) begin
        failures++;
        if (failures <= 10)
          $display({"mismatch: expected ch %0d power %0d total %0d sat %0b,",
                    " got ch %0d power %0d total %0d sat %0b"},
                   want.chan, $signed(want.watts), $signed(want.total), want.clip,
                   ch, $signed(watts), $signed(total), clip);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid;
  logic in_stall;
  logic [1:0] channel;
  logic [11:0] sample;
  logic window_end;
  logic out_valid;
  logic out_stall;
  logic [1:0] result_channel;
  logic signed [ppm_pkg::POWER_W-1:0] power_watts;
  logic signed [ppm_pkg::TOTAL_W-1:0] pump_total_watts;
  logic saturated;
  logic cfg_we;
  logic [ppm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ppm_pkg::CFG_W-1:0] cfg_data;

  power_ledger meter = new();
  int samples_sent = 0;
  int readings_taken = 0;
  int quiet_cycles = 0;
  bit steady_in = 1'b0;
  bit steady_out = 1'b0;

  always #2 clk = ~clk;

  peak_to_peak_phase_power_meter DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .channel(channel),
    .sample(sample),
    .window_end(window_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_channel(result_channel),
    .power_watts(power_watts),
    .pump_total_watts(pump_total_watts),
    .saturated(saturated),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) meter.take_sample(channel, sample, window_end);
      if (out_valid && !out_stall)
        meter.check_reading(result_channel, power_watts, pump_total_watts, saturated);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stall before each result, with calm stretches
  initial begin
    int hold;
    out_stall <= 1'b0;
    forever begin
      if (readings_taken % 16 == 0) steady_out = ($urandom_range(0, 3) == 0);
      hold = steady_out ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      readings_taken++;
    end
  end

  // returns at the edge where the request was taken, valid still high
  task automatic send_sample(input logic [1:0] ch, input logic [11:0] s, input logic last);
    int gap;
    if (samples_sent % 64 == 0) steady_in = ($urandom_range(0, 3) == 0);
    gap = steady_in ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    channel <= ch;
    sample <= s;
    window_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
  endtask

  task automatic send_window();
    int len;
    int lo;
    int spread;
    int kind;
    kind = $urandom_range(0, 9);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    if (kind < 3) spread = $urandom_range(100, 150);  // around the small-span cutoff
    else if (kind < 5) spread = $urandom_range(0, 99);
    else if (kind < 8) spread = $urandom_range(150, 4095);
    else spread = 4095;
    lo = $urandom_range(0, 4095 - spread);
    for (int k = 0; k < len; k++)
      send_sample(2'($urandom_range(0, 3)),
                  12'((kind == 9) ? $urandom_range(0, 4095) : lo + $urandom_range(0, spread)),
                  k == len - 1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (meter.readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // back-to-back writes keep the enable high, spare index is written too
  task automatic program_meter(input logic [ppm_pkg::CFG_W-1:0] sl,
                               input logic [ppm_pkg::CFG_W-1:0] off,
                               input logic [ppm_pkg::CFG_W-1:0] vo);
    logic [ppm_pkg::CFG_IDX_W-1:0] idx[4];
    logic [ppm_pkg::CFG_W-1:0] vals[4];
    idx = '{ppm_pkg::CFG_SLOPE, ppm_pkg::CFG_OFFSET, ppm_pkg::CFG_VOLT, CFG_SPARE};
    vals = '{sl, off, vo, ppm_pkg::CFG_W'($urandom)};
    for (int k = 0; k < 4; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= vals[k];
      @(posedge clk);
      meter.set_register(idx[k], vals[k]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_windows(input int count);
    int target;
    target = samples_sent + count;
    while (samples_sent < target) send_window();
  endtask

  initial begin
    in_valid <= 1'b0;
    channel <= '0;
    sample <= '0;
    window_end <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(2'd0, 12'd0, 1'b1);        // lone sample, zero span
    send_sample(2'd1, 12'hfff, 1'b0);
    send_sample(2'd1, 12'h000, 1'b1);      // full span
    send_sample(2'd2, 12'd100, 1'b0);
    send_sample(2'd2, 12'd224, 1'b1);      // one count below cutoff
    send_sample(2'd2, 12'd100, 1'b0);
    send_sample(2'd2, 12'd225, 1'b1);      // right at cutoff
    send_sample(2'd3, 12'h000, 1'b0);
    send_sample(2'd3, 12'haaa, 1'b0);
    send_sample(2'd3, 12'h555, 1'b0);
    send_sample(2'd3, 12'hfff, 1'b1);      // heating rod, total unchanged
    send_sample(2'd0, 12'd3000, 1'b0);
    send_sample(2'd1, 12'd500, 1'b0);
    send_sample(2'd0, 12'd2048, 1'b1);     // window shared across channels
    send_sample(2'd0, 12'd2048, 1'b1);
    random_windows(300);

    settle();
    program_meter(17'h0ffff, 17'h0ffff, 17'h003ff);   // drives into saturation
    random_windows(310);
    settle();
    program_meter(17'h10000, 17'h10000, 17'h003ff);   // zero slope, most negative offset
    random_windows(310);
    settle();
    program_meter(ppm_pkg::CFG_W'($urandom), ppm_pkg::CFG_W'($urandom), 17'h00000);
    random_windows(310);
    settle();
    program_meter(ppm_pkg::CFG_W'($urandom), ppm_pkg::CFG_W'($urandom),
                  ppm_pkg::CFG_W'($urandom));
    random_windows(310);
    settle();
    program_meter({1'b1, ppm_pkg::SLOPE_RESET}, ppm_pkg::CFG_W'(-$urandom_range(0, 20000)),
                  17'd230);
    random_windows(310);

    settle();
    if (meter.failures == 0 && meter.readings.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: peak_to_peak_phase_power_meter.f
hw/rtl/ppm_pkg.sv
hw/rtl/ppm_ctrl.sv
hw/rtl/ppm_datapath.sv
hw/rtl/peak_to_peak_phase_power_meter.sv
tb/sv/tb_peak_to_peak_phase_power_meter.sv
